/* rtl/core/kmpt_pkg.sv */
`default_nettype none

package kmpt_pkg;

    // matrix geometry
    localparam int unsigned KEY_CODES      = 128;
    localparam int unsigned MATRIX_COLUMNS = 10;
    localparam int unsigned TABLE_SIZE     = 70;

    // current key value meaning no key is held
    localparam logic [7:0] NO_KEY = 8'hFF;

    // probe item
    typedef struct packed {
        logic [6:0] key_code;
        logic       pressed;
    } kmpt_in_t;

    // result item
    typedef struct packed {
        logic [7:0] current_key;
        logic [6:0] last_key;
        logic       new_press;
        logic [7:0] ascii_char;
        logic       ever_pressed;
    } kmpt_out_t;

    // row/column character table, rows 1 to 7
    localparam logic [7:0] CHAR_TABLE [TABLE_SIZE] = '{
        8'd81, 8'd51, 8'd52, 8'd53, 8'd0,  8'd56, 8'd0,  8'd45, 8'd94, 8'd136,
        8'd0,  8'd87, 8'd69, 8'd84, 8'd55, 8'd73, 8'd57, 8'd48, 8'd95, 8'd138,
        8'd49, 8'd50, 8'd68, 8'd82, 8'd54, 8'd85, 8'd79, 8'd80, 8'd91, 8'd139,
        8'd0,  8'd65, 8'd88, 8'd70, 8'd89, 8'd74, 8'd75, 8'd64, 8'd58, 8'd13,
        8'd0,  8'd83, 8'd67, 8'd71, 8'd72, 8'd78, 8'd76, 8'd59, 8'd93, 8'd127,
        8'd9,  8'd90, 8'd32, 8'd86, 8'd66, 8'd77, 8'd44, 8'd46, 8'd47, 8'd135,
        8'd27, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd92, 8'd137
    };

    // character of a key code; row 0 and positions past the table give 0
    function automatic logic [7:0] key_char(input logic [6:0] code);
        logic [2:0] row;
        logic [3:0] col;
        logic [7:0] pos;
        row = code[6:4];
        col = code[3:0];
        pos = 8'(8'(row - 3'd1) * 8'(MATRIX_COLUMNS)) + 8'(col);
        if (row == 3'd0)
        begin
            return 8'd0;
        end
        if (pos >= 8'(TABLE_SIZE))
        begin
            return 8'd0;
        end
        return CHAR_TABLE[pos[6:0]];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/kmpt_keystore.sv */
`default_nettype none

module kmpt_keystore (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire kmpt_pkg::kmpt_in_t  item,
    input  wire logic                update_en,
    output kmpt_pkg::kmpt_out_t      result,
    output logic                     ignored
);
    import kmpt_pkg::*;

    logic [KEY_CODES-1:0] held_reg;
    logic [KEY_CODES-1:0] history_reg;
    logic [7:0]           current_key_reg;
    logic [7:0]           current_key_next;
    logic [6:0]           last_key_reg;
    logic [6:0]           last_key_next;

    logic [6:0] idx;
    logic       held_now;
    logic       fresh;

    // per-key lookup
    assign idx      = item.key_code;
    assign held_now = held_reg[idx];
    assign fresh    = item.pressed && !held_now;
    assign ignored  = {1'b0, item.key_code[3:0]} >= 5'(MATRIX_COLUMNS);

    // current and last key update
    always_comb
    begin
        current_key_next = current_key_reg;
        last_key_next    = last_key_reg;
        if (item.pressed)
        begin
            if (fresh)
            begin
                current_key_next = {1'b0, item.key_code};
                last_key_next    = item.key_code;
            end
        end
        else if (current_key_reg == {1'b0, item.key_code})
        begin
            current_key_next = NO_KEY;
        end
    end

    // result as seen after this probe
    always_comb
    begin
        result.current_key  = current_key_next;
        result.last_key     = last_key_next;
        result.new_press    = fresh;
        result.ascii_char   = key_char(item.key_code);
        result.ever_pressed = item.pressed || history_reg[idx];
    end

    // key state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg        <= '0;
            history_reg     <= '0;
            current_key_reg <= 8'd0;
            last_key_reg    <= 7'd0;
        end
        else if (update_en && !ignored)
        begin
            held_reg[idx]   <= item.pressed;
            if (item.pressed)
            begin
                history_reg[idx] <= 1'b1;
            end
            current_key_reg <= current_key_next;
            last_key_reg    <= last_key_next;
        end
    end

    // a committed press leaves the key held and in the history
    assert property (@(posedge clk) disable iff (!rst_n)
        update_en && !ignored && item.pressed |=> held_reg[$past(idx)] && history_reg[$past(idx)])
        else $error("pressed key not recorded");

    // a committed release clears the held bit
    assert property (@(posedge clk) disable iff (!rst_n)
        update_en && !ignored && !item.pressed |=> !held_reg[$past(idx)])
        else $error("released key still held");

    // current key is a key code or none
    assert property (@(posedge clk) disable iff (!rst_n)
        current_key_reg[7] |-> current_key_reg == NO_KEY)
        else $error("current key out of range");

    // ignored probes leave the key state alone
    assert property (@(posedge clk) disable iff (!rst_n)
        update_en && ignored |=> $stable(current_key_reg) && $stable(last_key_reg))
        else $error("ignored probe changed state");

endmodule

`default_nettype wire

/* rtl/core/key_matrix_press_tracker_core.sv */
//  channel | signals                          | payload
//  --------+----------------------------------+--------------------------------------
//  probe   | in_valid, in_ready, in_data      | key_code, pressed
//  result  | out_valid, out_ready, out_data   | current_key, last_key, new_press,
//          |                                  | ascii_char, ever_pressed
//
//  one probe per cycle sustained while results are taken; a probe loads the input
//  register at its transfer, then the key-state update and the result register load
//  together once the result register is free
//  probes with a column of ten or more update nothing and give no result
//  reset clears all held and history bits and both key registers at once
//  a stalled result holds the result register; the input register takes one
//  more probe, then in_ready drops until the result is taken, unless that probe is ignored
`default_nettype none

module key_matrix_press_tracker_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire kmpt_pkg::kmpt_in_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output kmpt_pkg::kmpt_out_t      out_data
);
    import kmpt_pkg::*;

    logic      in_valid_reg;
    kmpt_in_t  in_data_reg;
    logic      out_valid_reg;
    kmpt_out_t out_data_reg;

    kmpt_out_t result;
    logic      ignored;
    logic      out_free;
    logic      advance;

    // stage advance: ignored probes need no room at the output
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && (ignored || out_free);
    assign in_ready = !in_valid_reg || advance;

    kmpt_keystore u_keystore (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (in_data_reg),
        .update_en (advance),
        .result    (result),
        .ignored   (ignored)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && !ignored;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && !ignored)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a fresh press makes the probed key current
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.new_press |-> out_data.current_key == {1'b0, out_data.last_key})
        else $error("fresh press not current");

    // a fresh press is in the history
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.new_press |-> out_data.ever_pressed)
        else $error("fresh press missing from history");

    // back-pressure only with a probe waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without cause");

    // a waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("pending result lost");

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import kmpt_pkg::*;

    localparam int unsigned RANDOM_PROBES = 1250;
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned DRAIN_CYCLES  = 10;
    localparam int unsigned PHASE_LENGTH  = 150;
    localparam int unsigned CHAR_COUNT    = 70;

    // idling pattern, stepped through as probes go in
    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_SENDER_IDLE,
        FLOW_RECEIVER_STALL,
        FLOW_BOTH_IDLE
    } flow_mode_t;

    // characters by position (row - 1) * columns + column
    localparam logic [7:0] KEY_CHARS [CHAR_COUNT] = '{
        8'd81, 8'd51, 8'd52, 8'd53, 8'd0,  8'd56, 8'd0,  8'd45, 8'd94, 8'd136,
        8'd0,  8'd87, 8'd69, 8'd84, 8'd55, 8'd73, 8'd57, 8'd48, 8'd95, 8'd138,
        8'd49, 8'd50, 8'd68, 8'd82, 8'd54, 8'd85, 8'd79, 8'd80, 8'd91, 8'd139,
        8'd0,  8'd65, 8'd88, 8'd70, 8'd89, 8'd74, 8'd75, 8'd64, 8'd58, 8'd13,
        8'd0,  8'd83, 8'd67, 8'd71, 8'd72, 8'd78, 8'd76, 8'd59, 8'd93, 8'd127,
        8'd9,  8'd90, 8'd32, 8'd86, 8'd66, 8'd77, 8'd44, 8'd46, 8'd47, 8'd135,
        8'd27, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd92, 8'd137
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    kmpt_in_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    kmpt_out_t out_data;

    kmpt_in_t   pending_probes[$];
    kmpt_out_t  expected_reports[$];
    kmpt_out_t  oldest_report;
    int unsigned probes_sent = 0;
    int unsigned quiet_cycles = 0;
    int unsigned scan_probes = 0;
    int unsigned failures = 0;
    logic       timed_out = 1'b0;
    flow_mode_t flow_mode;

    // tracker state as seen from outside
    logic [KEY_CODES-1:0] key_held    = '0;
    logic [KEY_CODES-1:0] key_history = '0;
    logic [7:0]           held_key    = 8'd0;
    logic [6:0]           newest_key  = 7'd0;

    key_matrix_press_tracker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign flow_mode = flow_mode_t'((probes_sent / PHASE_LENGTH) % 4);

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [7:0] char_of_key(input logic [6:0] code);
        int unsigned position;
        if (code[6:4] == 3'd0)
        begin
            return 8'd0;
        end
        position = (int'(code[6:4]) - 1) * MATRIX_COLUMNS + int'(code[3:0]);
        if (position >= CHAR_COUNT)
        begin
            return 8'd0;
        end
        return KEY_CHARS[position];
    endfunction

    // update the key state for one probe and queue the report it gives
    function automatic void track_probe(input kmpt_in_t probe);
        kmpt_out_t  report;
        logic [6:0] code;
        code = probe.key_code;
        if (code[3:0] >= MATRIX_COLUMNS)
        begin
            return;
        end
        report.new_press = 1'b0;
        if (probe.pressed)
        begin
            if (!key_held[code])
            begin
                held_key         = {1'b0, code};
                newest_key       = code;
                report.new_press = 1'b1;
            end
            key_held[code]    = 1'b1;
            key_history[code] = 1'b1;
        end
        else
        begin
            key_held[code] = 1'b0;
            if (held_key == {1'b0, code})
            begin
                held_key = NO_KEY;
            end
        end
        report.current_key  = held_key;
        report.last_key     = newest_key;
        report.ascii_char   = char_of_key(code);
        report.ever_pressed = key_history[code];
        expected_reports.push_back(report);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    function automatic logic sender_idles();
        if (flow_mode == FLOW_SENDER_IDLE)
        begin
            return $urandom_range(0, 99) < 58;
        end
        if (flow_mode == FLOW_BOTH_IDLE)
        begin
            return $urandom_range(0, 99) < 18;
        end
        return 1'b0;
    endfunction

    function automatic logic receiver_stalls();
        if (flow_mode == FLOW_RECEIVER_STALL)
        begin
            return $urandom_range(0, 99) < 58;
        end
        if (flow_mode == FLOW_BOTH_IDLE)
        begin
            return $urandom_range(0, 99) < 18;
        end
        return 1'b0;
    endfunction

    function automatic void queue_probe(input logic [6:0] code, input logic down);
        kmpt_in_t probe;
        probe.key_code = code;
        probe.pressed  = down;
        pending_probes.push_back(probe);
        if (code[3:0] < MATRIX_COLUMNS)
        begin
            scan_probes++;
        end
    endfunction

    // a key inside the matrix
    function automatic logic [6:0] matrix_key();
        logic [6:0] code;
        code[6:4] = 3'($urandom_range(0, 7));
        code[3:0] = 4'($urandom_range(0, MATRIX_COLUMNS - 1));
        return code;
    endfunction

    // directed probes, then press/release sequences mixed with noise
    task automatic build_stimulus();
        logic [6:0] first_key;
        logic [6:0] second_key;
        int unsigned pick;
        // key 0 matches the reset current key, so its release clears it
        queue_probe(7'h00, 1'b0);
        queue_probe(7'h00, 1'b1);
        queue_probe(7'h00, 1'b1);
        queue_probe(7'h79, 1'b1);
        queue_probe(7'h00, 1'b0);
        queue_probe(7'h79, 1'b0);
        // columns outside the matrix, then overlapping presses, repeats and releases inside it
        queue_probe(7'h7F, 1'b1);
        queue_probe(7'h7A, 1'b0);
        queue_probe(7'h0F, 1'b1);
        queue_probe(7'h4B, 1'b1);
        queue_probe(7'h10, 1'b1);
        queue_probe(7'h10, 1'b0);
        queue_probe(7'h10, 1'b1);
        queue_probe(7'h09, 1'b1);
        queue_probe(7'h70, 1'b1);
        queue_probe(7'h68, 1'b0);
        queue_probe(7'h61, 1'b1);
        queue_probe(7'h70, 1'b0);
        queue_probe(7'h61, 1'b0);
        queue_probe(7'h09, 1'b0);
        queue_probe(7'h10, 1'b0);
        queue_probe(7'h55, 1'b1);
        queue_probe(7'h55, 1'b1);
        queue_probe(7'h55, 1'b0);
        scan_probes = 0;
        while (scan_probes < RANDOM_PROBES)
        begin
            pick = $urandom_range(0, 99);
            first_key  = matrix_key();
            second_key = matrix_key();
            if (pick < 35)
            begin
                // press, maybe repeat while held, then release
                queue_probe(first_key, 1'b1);
                if ($urandom_range(0, 1) == 0)
                begin
                    queue_probe(first_key, 1'b1);
                end
                queue_probe(first_key, 1'b0);
            end
            else if (pick < 60)
            begin
                // overlapping presses, released in either order
                queue_probe(first_key, 1'b1);
                queue_probe(second_key, 1'b1);
                if ($urandom_range(0, 1) == 0)
                begin
                    queue_probe(first_key, 1'b0);
                    queue_probe(second_key, 1'b0);
                end
                else
                begin
                    queue_probe(second_key, 1'b0);
                    queue_probe(first_key, 1'b0);
                end
            end
            else if (pick < 75)
            begin
                // key left held, or a release without a press
                queue_probe(first_key, 1'($urandom_range(0, 1)));
            end
            else
            begin
                // anything at all, outside columns included
                queue_probe(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // probe driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                track_probe(in_data);
                probes_sent <= probes_sent + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_probes.size() != 0 && !sender_idles())
                begin
                    in_data  <= pending_probes.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("result transfer with none expected: %h", out_data);
                    failures++;
                end
                else
                begin
                    oldest_report = expected_reports.pop_front();
                    check_field("current_key", oldest_report.current_key,
                                out_data.current_key);
                    check_field("last_key", oldest_report.last_key, out_data.last_key);
                    check_field("new_press", oldest_report.new_press, out_data.new_press);
                    check_field("ascii_char", oldest_report.ascii_char,
                                out_data.ascii_char);
                    check_field("ever_pressed", oldest_report.ever_pressed,
                                out_data.ever_pressed);
                end
            end
            out_ready <= !receiver_stalls();
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        build_stimulus();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (pending_probes.size() != 0 || in_valid || expected_reports.size() != 0)
        begin
            @(posedge clk);
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $error("no transfer for %0d cycles", quiet_cycles);
                timed_out = 1'b1;
                break;
            end
        end
        if (!timed_out)
        begin
            repeat (DRAIN_CYCLES) @(posedge clk);
            if (expected_reports.size() != 0)
            begin
                $error("%0d expected results never arrived", expected_reports.size());
                failures++;
            end
        end
        if (!timed_out && failures == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
